// File: rtl/l3d_pkg.sv
// Shared types and codes of the 3D color lookup core.
`timescale 1ns / 1ps
package l3d_pkg;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic {
    REG_LUT_SIZE  = 1'b0,
    REG_LUT_VALID = 1'b1
  } reg_idx_e;

  localparam int unsigned ColorWidth = 16;
  localparam int unsigned SizeWidth  = 6;

endpackage

// File: rtl/l3d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module l3d_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 35937
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lut3d_trilinear_color_map_core.sv
// A lookup passes through the stage 1 to 6 registers and then the output register.
// Throughput: one item per cycle unless the output stalls. Eight replicated
// table RAMs, each written by every in-range load, read one corner each.
// Loads write the table in the same stage where lookups read it, keeping order.
// Reset clears the pipeline valids and sets lut_size to 33, lut_valid to 0;
// the table contents are undefined until loaded.
`timescale 1ns / 1ps
module lut3d_trilinear_color_map_core #(
  parameter int unsigned MAX_GRID  = 33,
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [l3d_pkg::SizeWidth-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [15:0]                         entry_index_i,
  input  logic [l3d_pkg::ColorWidth-1:0]      red_in_i,
  input  logic [l3d_pkg::ColorWidth-1:0]      green_in_i,
  input  logic [l3d_pkg::ColorWidth-1:0]      blue_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [l3d_pkg::ColorWidth-1:0]      red_out_o,
  output logic [l3d_pkg::ColorWidth-1:0]      green_out_o,
  output logic [l3d_pkg::ColorWidth-1:0]      blue_out_o,
  output logic                                applied_o
);

  localparam int unsigned CW    = l3d_pkg::ColorWidth;
  localparam int unsigned DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned GW    = $clog2(MAX_GRID);
  localparam int unsigned SW    = $clog2(MAX_GRID + 1);
  localparam int unsigned PW    = CW + SW;
  localparam longint unsigned OneVal = 64'd1 << FRAC_BITS;
  localparam longint unsigned ColMax = (OneVal > 64'hFFFF) ? 64'hFFFF : OneVal;

  typedef logic [2:0][CW-1:0] rgb_t;

  function automatic logic [CW-1:0] lerp(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                         input logic [FRAC_BITS-1:0] t);
    logic signed [CW:0]             d;
    logic signed [CW+FRAC_BITS+1:0] p;
    logic signed [CW+FRAC_BITS+1:0] sh;
    logic signed [CW+1:0]           s;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    p  = d * $signed({1'b0, t});
    sh = p >>> FRAC_BITS;            // floor shift
    s  = $signed({2'b00, a}) + sh[CW+1:0];
    return s[CW-1:0];
  endfunction

  // configuration registers
  logic [l3d_pkg::SizeWidth-1:0] lut_size_q;
  logic                          lut_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_size_q  <= l3d_pkg::SizeWidth'(33);
      lut_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (l3d_pkg::reg_idx_e'(cfg_idx_i))
        l3d_pkg::REG_LUT_SIZE:  lut_size_q  <= cfg_wdata_i;
        l3d_pkg::REG_LUT_VALID: lut_valid_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] s_eff;
  logic [SW-1:0] s_m1;
  logic          bypass;
  assign s_eff  = (int'(lut_size_q) > int'(MAX_GRID)) ? SW'(MAX_GRID) : SW'(lut_size_q);
  assign s_m1   = s_eff - SW'(1);
  assign bypass = !lut_valid_q || (s_eff < SW'(2));

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // valid chain: stage 1..6
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // stage 1: saturated color
  logic         op1_q;
  logic [15:0]  idx1_q;
  rgb_t         col1_q;
  rgb_t         col_in;
  rgb_t         col_sat;
  assign col_in = {blue_in_i, green_in_i, red_in_i};
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_sat[c] = (64'(col_in[c]) > ColMax) ? CW'(ColMax) : col_in[c];
    end
  end

  // stage 2: grid corners and fractions
  logic                           op2_q, byp2_q;
  logic [15:0]                    idx2_q;
  rgb_t                           col2_q;
  logic [2:0][GW-1:0]             lo2_q, hi2_q;
  logic [2:0][FRAC_BITS-1:0]      fr2_q;
  logic [2:0][PW-1:0]             scaled;
  logic [2:0][GW-1:0]             lo_c, hi_c;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = PW'(col1_q[c]) * PW'(s_m1);
      lo_c[c]   = scaled[c][FRAC_BITS +: GW];
      hi_c[c]   = (SW'(lo_c[c]) >= s_m1) ? GW'(s_m1) : lo_c[c] + GW'(1);
    end
  end

  // stage 3: partial addresses (z*s + y)
  logic                      op3_q, byp3_q;
  logic [15:0]               idx3_q;
  rgb_t                      col3_q;
  logic [2:0][FRAC_BITS-1:0] fr3_q;
  logic [1:0][GW-1:0]        x3_q;
  logic [3:0][AW-1:0]        zy3_q;
  logic [3:0][AW-1:0]        zy_c;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      zy_c[j] = AW'(j[1] ? hi2_q[2] : lo2_q[2]) * AW'(s_eff)
              + AW'(j[0] ? hi2_q[1] : lo2_q[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q && (op3_q == l3d_pkg::OP_LOOKUP);  // drop loads
      v5_q <= v4_q;
      v6_q <= v5_q;
      out_valid_q <= v6_q;
    end
  end

  // stage 3 -> RAM: full corner addresses, or the load write
  logic [7:0][AW-1:0]   raddr;
  logic [7:0][3*CW-1:0] rdata;
  logic                 ram_we, ram_re;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      raddr[k] = zy3_q[k >> 1] * AW'(s_eff) + AW'(x3_q[k & 1]);
    end
  end
  assign ram_we = en && v3_q && (op3_q == l3d_pkg::OP_LOAD) && (int'(idx3_q) < int'(DEPTH));
  assign ram_re = en && v3_q && (op3_q == l3d_pkg::OP_LOOKUP) && !byp3_q;

  for (genvar k = 0; k < 8; k++) begin : g_bank
    l3d_ram #(.WIDTH(3 * CW), .DEPTH(DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (AW'(idx3_q)),
      .wdata_i (col3_q),
      .re_i    (ram_re),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
  end

  // stage 4..6: lerp along red, green, blue
  logic                      byp4_q, byp5_q, byp6_q;
  rgb_t                      col4_q, col5_q, col6_q;
  logic [2:0][FRAC_BITS-1:0] fr4_q;
  logic [2:0][FRAC_BITS-1:0] fr5_q, fr6_q;
  logic [2:0][3:0][CW-1:0]   e_c;
  logic [2:0][3:0][CW-1:0]   e5_q;
  logic [2:0][1:0][CW-1:0]   f_c;
  logic [2:0][1:0][CW-1:0]   f6_q;
  rgb_t                      g_c;
  rgb_t                      res_q;
  logic                      applied_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 4; i++) begin
        e_c[c][i] = lerp(rdata[2*i][c*CW +: CW], rdata[2*i+1][c*CW +: CW], fr4_q[0]);
      end
      for (int i = 0; i < 2; i++) begin
        f_c[c][i] = lerp(e5_q[c][2*i], e5_q[c][2*i+1], fr5_q[1]);
      end
      g_c[c] = lerp(f6_q[c][0], f6_q[c][1], fr6_q[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= operation_i;
      idx1_q <= entry_index_i;
      col1_q <= col_sat;

      op2_q  <= op1_q;
      idx2_q <= idx1_q;
      col2_q <= col1_q;
      byp2_q <= bypass;
      lo2_q  <= lo_c;
      hi2_q  <= hi_c;
      for (int c = 0; c < 3; c++) begin
        fr2_q[c] <= scaled[c][FRAC_BITS-1:0];
      end

      op3_q  <= op2_q;
      idx3_q <= idx2_q;
      col3_q <= col2_q;
      byp3_q <= byp2_q;
      fr3_q  <= fr2_q;
      x3_q   <= {hi2_q[0], lo2_q[0]};
      zy3_q  <= zy_c;

      byp4_q <= byp3_q;
      col4_q <= col3_q;
      fr4_q  <= fr3_q;

      byp5_q <= byp4_q;
      col5_q <= col4_q;
      fr5_q  <= fr4_q;
      e5_q   <= e_c;

      byp6_q <= byp5_q;
      col6_q <= col5_q;
      fr6_q  <= fr5_q;
      f6_q   <= f_c;

      res_q     <= byp6_q ? col6_q : g_c;
      applied_q <= !byp6_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = res_q[0];
  assign green_out_o = res_q[1];
  assign blue_out_o  = res_q[2];
  assign applied_o   = applied_q;

  a_applied_needs_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && applied_o |-> lut_valid_q)
    else $error("result applied with table not valid");

  a_no_rw_same_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table read and write issued by one item");

  a_out_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (64'(red_out_o) <= ColMax) && (64'(green_out_o) <= ColMax)
                    && (64'(blue_out_o) <= ColMax))
    else $error("result color above 1.0");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(res_q) && $stable(v6_q))
    else $error("pipeline moved during stall");

endmodule
